[hw/rtl/arlt_pkg.sv]
// Shared types, constants and codes for the address region lookup table.
package arlt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int TAG_BITS      = 16;
  localparam int ADDR_BITS     = 64;
  localparam int IDX_BITS      = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int NUM_TABLES    = 2;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [TAG_BITS-1:0]  tag_t;
  typedef logic [IDX_BITS-1:0]  idx_t;

  localparam addr_t ADDR_MAX = '1;

  // Item kind codes
  localparam logic [1:0] KIND_IMAGE   = 2'd0;
  localparam logic [1:0] KIND_ROUTINE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP  = 2'd2;

  // Table selectors
  localparam logic TBL_IMAGE   = 1'b0;
  localparam logic TBL_ROUTINE = 1'b1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] query_address;
    logic [63:0] region_start;
    logic [63:0] region_end;
    logic [15:0] region_tag;
  } item_t;

  typedef struct packed {
    logic        image_hit;
    logic [15:0] image_tag_out;
    logic        routine_hit;
    logic [15:0] routine_tag_out;
    logic        insert_dropped;
  } result_t;

  typedef struct packed {
    addr_t end_key;
    addr_t start_addr;
    tag_t  name_tag;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_issue;
  } ctrl_status_t;

endpackage

[hw/rtl/arlt_ram.sv]
// Generic simple dual-port RAM with registered read.
module arlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/arlt_ctrl.sv]
// Sequencer for the scan, drain and commit phases of one word.
module arlt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  arlt_pkg::ctrl_status_t status,
  output arlt_pkg::ctrl_cmd_t    cmd
);
  import arlt_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy       = 1'b1;
    cmd.load   = 1'b0;
    cmd.issue  = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_SCAN:   cmd.issue  = 1'b1;
      ST_DRAIN:  ;
      ST_COMMIT: cmd.commit = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

endmodule

[hw/rtl/arlt_datapath.sv]
// Region tables, scan counter, best-entry trackers and result register.
module arlt_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  arlt_pkg::item_t        request,
  input  arlt_pkg::ctrl_cmd_t    cmd,
  output arlt_pkg::ctrl_status_t status,
  output arlt_pkg::result_t      result,
  output logic                  done
);
  import arlt_pkg::*;

  // Latched word
  item_t item;
  addr_t ins_key;

  // Scan counter and read pipeline
  idx_t cnt;
  idx_t rd_idx;
  logic rd_valid;

  logic [NUM_TABLES-1:0][TABLE_ENTRIES-1:0] valid;
  logic [NUM_TABLES-1:0][ENTRY_BITS-1:0]    rdata;
  entry_t [NUM_TABLES-1:0]                  rd_entry;
  logic [NUM_TABLES-1:0]                    ent_valid;
  logic [NUM_TABLES-1:0]                    take_best;
  logic [NUM_TABLES-1:0]                    wr_en;

  // Lookup trackers, one per table
  logic [NUM_TABLES-1:0] found;
  addr_t [NUM_TABLES-1:0] best_key;
  addr_t [NUM_TABLES-1:0] best_start;
  tag_t  [NUM_TABLES-1:0] best_tag;
  logic  [NUM_TABLES-1:0] hit;

  // Insert trackers on the target table
  logic   match_found;
  idx_t   match_idx;
  logic   free_found;
  idx_t   free_idx;
  logic   tgt;
  entry_t tgt_entry;
  logic   tgt_valid;
  logic   hit_match;
  logic   hit_free;
  logic   is_insert;
  idx_t   wr_idx;
  entry_t wr_data;

  assign status.last_issue = (cnt == idx_t'(TABLE_ENTRIES - 1));

  assign tgt       = item.kind[0];
  assign is_insert = (item.kind == KIND_IMAGE) || (item.kind == KIND_ROUTINE);

  always_comb begin
    for (int t = 0; t < NUM_TABLES; t++) begin
      rd_entry[t]  = entry_t'(rdata[t]);
      ent_valid[t] = valid[t][rd_idx];
      take_best[t] = rd_valid && ent_valid[t] &&
                     (rd_entry[t].end_key >= item.query_address) &&
                     (!found[t] || (rd_entry[t].end_key < best_key[t]));
      hit[t]       = found[t] && (best_start[t] <= item.query_address) &&
                     (best_key[t] != ADDR_MAX);
    end
  end

  assign tgt_entry = rd_entry[tgt];
  assign tgt_valid = ent_valid[tgt];
  assign hit_match = rd_valid && tgt_valid && (tgt_entry.end_key == ins_key) && !match_found;
  assign hit_free  = rd_valid && !tgt_valid && !free_found;

  assign wr_idx             = match_found ? match_idx : free_idx;
  assign wr_data.end_key    = ins_key;
  assign wr_data.start_addr = item.region_start;
  assign wr_data.name_tag   = tag_t'(item.region_tag);

  always_comb begin
    for (int t = 0; t < NUM_TABLES; t++) begin
      wr_en[t] = cmd.commit && is_insert && (tgt == t[0]) && (match_found || free_found);
    end
  end

  for (genvar g = 0; g < NUM_TABLES; g++) begin : g_table
    arlt_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (TABLE_ENTRIES)
    ) u_ram (
      .clk   (clk),
      .we    (wr_en[g]),
      .waddr (wr_idx),
      .wdata (wr_data),
      .raddr (cnt),
      .rdata (rdata[g])
    );
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
      done     <= 1'b0;
      valid    <= '0;
    end else begin
      rd_valid <= cmd.issue;
      done     <= cmd.commit;
      for (int t = 0; t < NUM_TABLES; t++) begin
        if (wr_en[t] && !match_found) begin
          valid[t][free_idx] <= 1'b1;
        end
      end
    end
  end

  // Payload and trackers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item        <= request;
      ins_key     <= request.region_end - addr_t'(1);
      cnt         <= '0;
      found       <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
    end else begin
      if (cmd.issue) begin
        cnt <= cnt + idx_t'(1);
      end
      for (int t = 0; t < NUM_TABLES; t++) begin
        if (take_best[t]) begin
          found[t]      <= 1'b1;
          best_key[t]   <= rd_entry[t].end_key;
          best_start[t] <= rd_entry[t].start_addr;
          best_tag[t]   <= rd_entry[t].name_tag;
        end
      end
      if (hit_match) begin
        match_found <= 1'b1;
        match_idx   <= rd_idx;
      end
      if (hit_free) begin
        free_found <= 1'b1;
        free_idx   <= rd_idx;
      end
    end
    rd_idx <= cnt;
    if (cmd.commit) begin
      result.image_hit       <= (item.kind == KIND_LOOKUP) && hit[TBL_IMAGE];
      result.image_tag_out   <= ((item.kind == KIND_LOOKUP) && hit[TBL_IMAGE]) ?
                                16'(best_tag[TBL_IMAGE]) : 16'd0;
      result.routine_hit     <= (item.kind == KIND_LOOKUP) && hit[TBL_ROUTINE];
      result.routine_tag_out <= ((item.kind == KIND_LOOKUP) && hit[TBL_ROUTINE]) ?
                                16'(best_tag[TBL_ROUTINE]) : 16'd0;
      result.insert_dropped  <= is_insert && !match_found && !free_found;
    end
  end

endmodule

[hw/rtl/address_region_lookup_table.sv]
// Top level of the address region lookup table.
//
// Two region tables (images and routines) of TABLE_ENTRIES slots each. A word
// on request is taken at the rising edge where start is high and busy is low.
// Kinds: insert image region, insert routine region, lookup address.
// Every word, whatever its kind, sweeps both tables one slot per cycle through
// the registered read port of each table RAM; the sweep sets the rate.
// Each word steps through the scan state (all TABLE_ENTRIES slots), the drain
// state for the RAM read and the commit state, which registers the result;
// the result is then shown on result, marked by done for one cycle.
// One word at a time: busy stays high until then and drops in the cycle
// that done is shown, so the next word may start there.
// An insert overwrites the slot with the same end key, else fills the lowest
// free slot, else is dropped and insert_dropped is raised.
// A lookup reports, per table, the slot with the smallest end key at or above
// the address, and hits only when the address lies within that region.
// Reset (rst, synchronous) clears the valid bits and the sequencer; slot
// contents are left as they are and never used before being written.
// The receiver cannot stall: done is a one-cycle strobe and must be taken.
module address_region_lookup_table (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  arlt_pkg::item_t   request,
  output arlt_pkg::result_t result,
  output logic              done
);
  import arlt_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  // Sequence scan, drain and commit
  arlt_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  // Hold tables, trackers and the result register
  arlt_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .status  (status),
    .result  (result),
    .done    (done)
  );

endmodule

[sim/tb_top.sv]
// Testbench for the address region lookup table: directed and random words
// checked against a predictor.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import arlt_pkg::*;

  // The kind code that the block leaves unused: it must change nothing and
  // answer with an all-zero result.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Slowest correct run: roughly 600 words, each waiting out the longest idle
  // gap plus a full sweep of both tables. Allow several times that before
  // giving up.
  localparam int WATCHDOG_CYCLES = 1_000_000;

  logic    clk;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  item_t   request = '0;
  result_t result;
  logic    done;

  address_region_lookup_table i_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .result (result),
    .done   (done)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a shadow copy of both region tables, indexed by the
  // package table selectors.
  // ---------------------------------------------------------------------------
  addr_t region_key  [NUM_TABLES][TABLE_ENTRIES];
  addr_t region_base [NUM_TABLES][TABLE_ENTRIES];
  tag_t  region_name [NUM_TABLES][TABLE_ENTRIES];
  bit    region_live [NUM_TABLES][TABLE_ENTRIES];

  result_t pending_results[$];
  int      mismatches    = 0;
  int      cycle_count   = 0;
  bit      back_to_back  = 1'b0;

  // Insert a region into one table; return 1 when the table is full and the
  // word is dropped.
  function automatic logic store_region(input int t, input addr_t lo, input addr_t hi,
                                        input tag_t tag);
    addr_t key;
    int    free_idx;
    key      = hi - 64'd1;
    free_idx = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      // A live slot with the same end key is simply overwritten.
      if (region_live[t][i] && region_key[t][i] == key) begin
        region_base[t][i] = lo;
        region_name[t][i] = tag;
        return 1'b0;
      end
      if (!region_live[t][i] && free_idx < 0) free_idx = i;
    end
    if (free_idx < 0) return 1'b1;
    region_key[t][free_idx]  = key;
    region_base[t][free_idx] = lo;
    region_name[t][free_idx] = tag;
    region_live[t][free_idx] = 1'b1;
    return 1'b0;
  endfunction

  // Choose the live slot with the smallest end key at or above the address and
  // hit only when the address lies inside that region.
  function automatic void locate_region(input int t, input addr_t a, output logic hit,
                                        output logic [15:0] tag);
    int    best;
    addr_t end_excl;
    best = -1;
    hit  = 1'b0;
    tag  = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (region_live[t][i] && region_key[t][i] >= a &&
          (best < 0 || region_key[t][i] < region_key[t][best]))
        best = i;
    end
    if (best >= 0) begin
      // The exclusive end wraps to zero for an all-ones key, so that region
      // can shadow others but never hits.
      end_excl = region_key[t][best] + 64'd1;
      if (region_base[t][best] <= a && a < end_excl) begin
        hit = 1'b1;
        tag = 16'(region_name[t][best]);
      end
    end
  endfunction

  function automatic result_t predict_word(input item_t w);
    result_t     r;
    logic        hit;
    logic [15:0] tag;
    r = '0;
    case (w.kind)
      KIND_IMAGE: begin
        r.insert_dropped = store_region(TBL_IMAGE, w.region_start, w.region_end,
                                        tag_t'(w.region_tag));
      end
      KIND_ROUTINE: begin
        r.insert_dropped = store_region(TBL_ROUTINE, w.region_start, w.region_end,
                                        tag_t'(w.region_tag));
      end
      KIND_LOOKUP: begin
        locate_region(TBL_IMAGE, w.query_address, hit, tag);
        r.image_hit     = hit;
        r.image_tag_out = tag;
        locate_region(TBL_ROUTINE, w.query_address, hit, tag);
        r.routine_hit     = hit;
        r.routine_tag_out = tag;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic addr_t rand_addr64();
    return {$urandom, $urandom};
  endfunction

  // Cluster addresses at the bottom, the top and a few random pages so that
  // regions overlap and shadow one another; the rest spread over all 64 bits.
  function automatic addr_t pick_address();
    addr_t a;
    case ($urandom_range(0, 3))
      0:       a = rand_addr64();
      1:       a = addr_t'($urandom_range(0, 4095));
      2:       a = ADDR_MAX - addr_t'($urandom_range(0, 4095));
      default: a = {$urandom_range(0, 3), 32'h0} + addr_t'($urandom_range(0, 4095));
    endcase
    return a;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 19);
    if (back_to_back || r < 10) return 0;
    if (r < 18) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  function automatic item_t make_word(input logic [1:0] k, input addr_t qa, input addr_t lo,
                                      input addr_t hi, input logic [15:0] tag);
    item_t w;
    w.kind          = k;
    w.query_address = qa;
    w.region_start  = lo;
    w.region_end    = hi;
    w.region_tag    = tag;
    return w;
  endfunction

  // Fill every field with noise; the block ignores the fields the kind does
  // not use, which still exercises their bits.
  function automatic item_t noise_word(input logic [1:0] k);
    return make_word(k, rand_addr64(), rand_addr64(), rand_addr64(), 16'($urandom));
  endfunction

  function automatic int valid_count(input int t);
    int n;
    n = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) n += region_live[t][i];
    return n;
  endfunction

  function automatic bit pick_slot(input int t, output int idx);
    int n;
    n   = valid_count(t);
    idx = 0;
    if (n == 0) return 1'b0;
    n = $urandom_range(0, n - 1);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (region_live[t][i]) begin
        if (n == 0) begin
          idx = i;
          return 1'b1;
        end
        n--;
      end
    end
    return 1'b0;
  endfunction

  function automatic logic [1:0] insert_kind(input int t);
    return (t == TBL_IMAGE) ? KIND_IMAGE : KIND_ROUTINE;
  endfunction

  // Mostly well-formed regions, with some empty, inverted and random ones.
  function automatic item_t new_region_word(input int t);
    item_t w;
    addr_t lo;
    w  = noise_word(insert_kind(t));
    lo = pick_address();
    case ($urandom_range(0, 9))
      0:       w.region_end = lo;
      1:       w.region_end = lo - addr_t'($urandom_range(1, 500));
      2:       w.region_end = rand_addr64();
      default: w.region_end = lo + addr_t'($urandom_range(1, 600));
    endcase
    w.region_start = lo;
    return w;
  endfunction

  // Reuse the end key of a live slot so the insert overwrites it.
  function automatic item_t overwrite_word(input int t, input int idx);
    item_t w;
    w            = noise_word(insert_kind(t));
    w.region_end = region_key[t][idx] + 64'd1;
    if ($urandom_range(0, 1))
      w.region_start = region_key[t][idx] - addr_t'($urandom_range(0, 800));
    return w;
  endfunction

  // Aim most lookups inside or at the edges of stored regions.
  function automatic item_t lookup_word();
    item_t w;
    int    t;
    int    idx;
    addr_t key;
    addr_t base;
    addr_t span;
    w = noise_word(KIND_LOOKUP);
    t = $urandom_range(0, 1);
    if ($urandom_range(0, 9) < 7 && pick_slot(t, idx)) begin
      key  = region_key[t][idx];
      base = region_base[t][idx];
      case ($urandom_range(0, 5))
        0: w.query_address = key;
        1: w.query_address = key + 64'd1;
        2: w.query_address = base;
        3: w.query_address = base - 64'd1;
        default: begin
          span = key - base;
          if (base > key)
            w.query_address = key;
          else if (span == ADDR_MAX)
            w.query_address = rand_addr64();
          else
            w.query_address = base + rand_addr64() % (span + 64'd1);
        end
      endcase
    end else begin
      w.query_address = pick_address();
    end
    return w;
  endfunction

  // Present one word, hold it until the block takes it, record the expected
  // result, then idle for a random gap.
  task automatic send_word(input item_t w);
    int gap;
    start   <= 1'b1;
    request <= w;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(predict_word(w));
    gap = gap_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes of the fields, every kind, and the awkward region shapes.
  task automatic test_directed_cases();
    // Lookups into empty tables at both ends of the address space.
    send_word(make_word(KIND_LOOKUP, '0, '0, '0, '0));
    send_word(make_word(KIND_LOOKUP, ADDR_MAX, ADDR_MAX, ADDR_MAX, 16'hffff));
    // Plain regions, one per table, with extreme tags.
    send_word(make_word(KIND_IMAGE, '0, 64'h0, 64'h100, 16'hffff));
    send_word(make_word(KIND_ROUTINE, '0, 64'h80, 64'h200, 16'h0000));
    send_word(make_word(KIND_LOOKUP, 64'h0, '0, '0, '0));
    send_word(make_word(KIND_LOOKUP, 64'hff, '0, '0, '0));
    send_word(make_word(KIND_LOOKUP, 64'h100, '0, '0, '0));
    // Region end of zero: key is all ones, never hits.
    send_word(make_word(KIND_IMAGE, '0, 64'hffff_ffff_ffff_0000, 64'h0, 16'h1234));
    send_word(make_word(KIND_LOOKUP, ADDR_MAX, '0, '0, '0));
    // Inverted region shadows the address below it.
    send_word(make_word(KIND_IMAGE, '0, 64'h500, 64'h400, 16'haaaa));
    send_word(make_word(KIND_LOOKUP, 64'h3f0, '0, '0, '0));
    // Empty region.
    send_word(make_word(KIND_IMAGE, '0, 64'h600, 64'h600, 16'h5a5a));
    send_word(make_word(KIND_LOOKUP, 64'h5ff, '0, '0, '0));
    // Same end key as the inverted region: overwrite it with a proper one.
    send_word(make_word(KIND_IMAGE, '0, 64'h300, 64'h400, 16'h5555));
    send_word(make_word(KIND_LOOKUP, 64'h3f0, '0, '0, '0));
    // Region reaching just below the top of the address space.
    send_word(make_word(KIND_ROUTINE, '0, 64'h0, ADDR_MAX, 16'h8001));
    send_word(make_word(KIND_LOOKUP, ADDR_MAX - 64'd1, '0, '0, '0));
    send_word(make_word(KIND_LOOKUP, 64'h200, '0, '0, '0));
    // Unused kind with all-ones and all-zero fields.
    send_word(make_word(KIND_UNUSED, ADDR_MAX, ADDR_MAX, ADDR_MAX, 16'hffff));
    send_word(make_word(KIND_UNUSED, '0, '0, '0, '0));
    // Overwrite the top routine region with an empty one, then probe it.
    send_word(make_word(KIND_ROUTINE, '0, ADDR_MAX, ADDR_MAX, 16'h7fff));
    send_word(make_word(KIND_LOOKUP, ADDR_MAX - 64'd1, '0, '0, '0));
  endtask

  // Random mix of inserts, overwrites, lookups and the odd unused word.
  task automatic test_mixed_traffic(input int n_words);
    int    r;
    int    t;
    int    idx;
    item_t w;
    for (int i = 0; i < n_words; i++) begin
      // Alternate stretches of back-to-back words with stretches of gaps.
      if (i % 40 == 0) back_to_back = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      t = $urandom_range(0, 1);
      if (r < 2)
        w = noise_word(KIND_UNUSED);
      else if (r < 40)
        w = ($urandom_range(0, 99) < 35 && pick_slot(t, idx)) ? overwrite_word(t, idx)
                                                               : new_region_word(t);
      else
        w = lookup_word();
      send_word(w);
    end
    back_to_back = 1'b0;
  endtask

  // Fill each table to capacity, then push it past: new keys drop, an
  // overwrite of a live key still goes in.
  task automatic test_full_tables();
    int    idx;
    item_t w;
    for (int t = 0; t < NUM_TABLES; t++) begin
      while (valid_count(t) < TABLE_ENTRIES) begin
        w              = noise_word(insert_kind(t));
        w.region_start = w.region_end - addr_t'($urandom_range(0, 70000));
        send_word(w);
        if ($urandom_range(0, 7) == 0) send_word(lookup_word());
      end
      repeat (3) send_word(new_region_word(t));
      if (pick_slot(t, idx)) send_word(overwrite_word(t, idx));
      repeat (3) send_word(lookup_word());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every done strobe must match the oldest expectation.
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && done === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with none expected, actual %h", $time, result);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        compare_field("image_hit", 16'(want.image_hit), 16'(result.image_hit));
        compare_field("image_tag_out", want.image_tag_out, result.image_tag_out);
        compare_field("routine_hit", 16'(want.routine_hit), 16'(result.routine_hit));
        compare_field("routine_tag_out", want.routine_tag_out, result.routine_tag_out);
        compare_field("insert_dropped", 16'(want.insert_dropped),
                      16'(result.insert_dropped));
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= WATCHDOG_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int t = 0; t < NUM_TABLES; t++)
      for (int i = 0; i < TABLE_ENTRIES; i++) region_live[t][i] = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed_cases();
    test_mixed_traffic(250);
    test_full_tables();
    test_mixed_traffic(150);

    // Drop start so the last word is not taken again once busy falls.
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Allow a full sweep for any stray result to show up.
    repeat (TABLE_ENTRIES + 8) @(posedge clk);

    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
